FILE: hw/rtl/brs_pkg.sv
// Shared types and constants for the bitmap range set engine.
package brs_pkg;

	localparam int WORD_BITS   = 64;
	localparam int STORE_WORDS = 1024;
	localparam int DATA_W      = 64;
	localparam int LOG2W       = $clog2(WORD_BITS);
	localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int TOTAL_BITS  = WORD_BITS * STORE_WORDS;
	localparam int END_W       = ($clog2(TOTAL_BITS) + 2 > 18) ? $clog2(TOTAL_BITS) + 2 : 18;

	typedef enum logic [1:0] {
		REQ_SET  = 2'd0,
		REQ_ZERO = 2'd1,
		REQ_OR   = 2'd2,
		REQ_READ = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CLEAR = 4'b0010,
		ST_RUN   = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

endpackage

FILE: hw/rtl/bitmap_range_set_engine.sv
// Bitmap range set engine: word-organized bit store with range set, prefix zero and word access.
//
// Input channel (in_valid / in_stall) takes one request item; the output channel
// (out_valid / out_stall) returns exactly one result item per request, in order.
// Bit 0 of the bitmap is the most significant bit of word 0.
// A request walks its words through the store, one word per cycle: set and or-word
// reads are issued back to back and each read word is ORed and written back in the
// next cycle; a zero prefix writes zeros without reading, and read-word only reads.
// An empty request goes straight to its result. The next item is accepted in the
// cycle after the result is loaded, so the input stays stalled during the walk.
// The next item is accepted once the current one has its result in the output
// register, so a result waiting on a stalled receiver does not block the next
// request; a second finished result waits until the output register is taken.
// After reset the store is swept to zero, one word per cycle; in_stall stays high
// during that sweep.
module bitmap_range_set_engine
	import brs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [15:0]       start_bit,
	input  logic [16:0]       bit_count,
	input  logic [9:0]        word_index,
	input  logic [63:0]       word_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] read_data,
	output logic              status
);

	localparam logic [WORD_BITS-1:0] ONES = '1;

	logic [WORD_BITS-1:0] store_mem [STORE_WORDS];

	state_t               state_q;
	req_t                 op_q;
	logic [AW-1:0]        cur_q;
	logic [AW-1:0]        first_q;
	logic [AW-1:0]        last_q;
	logic [LOG2W-1:0]     first_off_q;
	logic [LOG2W-1:0]     last_off_q;
	logic [WORD_BITS-1:0] data_q;
	logic                 more_q;
	logic                 res_status_q;
	logic [WORD_BITS-1:0] res_data_q;
	logic [WORD_BITS-1:0] rd_data_q;

	logic                 valid_s1;
	logic [AW-1:0]        addr_s1;
	logic [WORD_BITS-1:0] mask_s1;

	logic                 out_valid_q;
	logic [DATA_W-1:0]    read_data_q;
	logic                 status_q;

	// Request decode at acceptance.
	logic [END_W-1:0] end_full;
	logic [END_W-1:0] end_c;
	logic [END_W-1:0] end_m1;
	logic             set_clip;
	logic             set_work;
	logic [END_W-1:0] zero_words;
	logic             zero_clip;
	logic             idx_bad;
	logic             work;
	logic             clip;
	logic [AW-1:0]    dec_first;
	logic [AW-1:0]    dec_last;
	logic [LOG2W-1:0] dec_first_off;
	logic [LOG2W-1:0] dec_last_off;

	always_comb begin
		end_full   = END_W'(start_bit) + END_W'(bit_count);
		set_clip   = end_full > END_W'(TOTAL_BITS);
		end_c      = set_clip ? END_W'(TOTAL_BITS) : end_full;
		end_m1     = end_c - END_W'(1);
		set_work   = (bit_count != '0) && (END_W'(start_bit) < end_c);
		zero_words = (END_W'(bit_count) + END_W'(WORD_BITS - 1)) >> LOG2W;
		zero_clip  = zero_words > END_W'(STORE_WORDS);
		idx_bad    = 32'(word_index) >= 32'(STORE_WORDS);

		dec_first_off = LOG2W'(start_bit);
		dec_last_off  = LOG2W'(end_m1);
		case (req_type)
			REQ_SET: begin
				work      = set_work;
				clip      = set_clip && (bit_count != '0);
				dec_first = AW'(END_W'(start_bit) >> LOG2W);
				dec_last  = AW'(end_m1 >> LOG2W);
			end
			REQ_ZERO: begin
				work      = zero_words != '0;
				clip      = zero_clip;
				dec_first = '0;
				dec_last  = zero_clip ? AW'(STORE_WORDS - 1) : AW'(zero_words - END_W'(1));
			end
			default: begin
				work      = !idx_bad;
				clip      = idx_bad;
				dec_first = AW'(word_index);
				dec_last  = AW'(word_index);
			end
		endcase
	end

	logic accept;
	logic out_take;
	logic out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// Per-word edge mask for a set range: first and last words may be partial.
	logic [LOG2W-1:0]     mask_lo;
	logic [LOG2W-1:0]     mask_hi;
	logic [WORD_BITS-1:0] span;
	logic [WORD_BITS-1:0] issue_mask;

	always_comb begin
		mask_lo = (cur_q == first_q) ? first_off_q : '0;
		mask_hi = (cur_q == last_q) ? last_off_q : LOG2W'(WORD_BITS - 1);
		span    = (ONES >> mask_lo) & (ONES << (LOG2W'(WORD_BITS - 1) - mask_hi));
		case (op_q)
			REQ_SET:  issue_mask = span;
			REQ_OR:   issue_mask = data_q;
			default:  issue_mask = '0;
		endcase
	end

	// Store port control.
	logic                 rd_en;
	logic                 mod_wr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [WORD_BITS-1:0] merged;

	always_comb begin
		rd_en   = (state_q == ST_RUN) && more_q && (op_q != REQ_ZERO);
		mod_wr  = valid_s1 && (op_q != REQ_READ);
		merged  = rd_data_q | mask_s1;
		wr_en   = mod_wr || (state_q == ST_CLEAR) ||
			((state_q == ST_RUN) && more_q && (op_q == REQ_ZERO));
		wr_addr = mod_wr ? addr_s1 : cur_q;
		wr_data = mod_wr ? merged : '0;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= store_mem[cur_q];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= req_t'(req_type);
			first_q      <= dec_first;
			last_q       <= dec_last;
			first_off_q  <= dec_first_off;
			last_off_q   <= dec_last_off;
			data_q       <= word_data[WORD_BITS-1:0];
			res_status_q <= clip;
			res_data_q   <= '0;
		end else if (valid_s1 && (op_q == REQ_OR || op_q == REQ_READ)) begin
			res_data_q <= merged;
		end
		if (rd_en) begin
			addr_s1 <= cur_q;
			mask_s1 <= issue_mask;
		end
		if (out_load) begin
			read_data_q <= DATA_W'(res_data_q);
			status_q    <= res_status_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cur_q       <= '0;
			more_q      <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (cur_q == AW'(STORE_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						cur_q <= cur_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cur_q   <= dec_first;
						more_q  <= work;
						state_q <= work ? ST_RUN : ST_FIN;
					end
				end
				ST_RUN: begin
					if (more_q) begin
						if (cur_q == last_q) begin
							more_q <= 1'b0;
						end else begin
							cur_q <= cur_q + AW'(1);
						end
					end else if (!valid_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the bitmap range set engine: directed table, random requests, mirror.
`timescale 1ns / 1ps

module tb_top
	import brs_pkg::*;
;

	typedef struct packed {
		req_t        kind;
		logic [15:0] start_bit;
		logic [16:0] bit_count;
		logic [9:0]  word_index;
		logic [63:0] word_data;
	} bitmap_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              status;
	} bitmap_result_t;

	typedef struct packed {
		bitmap_req_t    req;
		logic           typed;
		bitmap_result_t want;
	} directed_row_t;

	localparam int RANDOM_ITEMS = 650;
	localparam int DIR_ROWS     = 27;
	localparam logic [WORD_BITS-1:0] FULL_WORD = '1;
	localparam logic [63:0] ONES_WORD = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] PATTERN   = 64'hA5A5_0F0F_3C3C_9696;

	// Rows with typed set carry an expectation that is plain from the request itself.
	localparam directed_row_t DIRECTED [DIR_ROWS] = '{
		'{'{REQ_READ, 16'd0,     17'd0,      10'd0,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_READ, 16'd0,     17'd0,      10'd1023, 64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_SET,  16'd0,     17'd0,      10'd0,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_ZERO, 16'd0,     17'd0,      10'd0,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_SET,  16'd0,     17'd1,      10'd0,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_READ, 16'd0,     17'd0,      10'd0,    64'd0},     1'b1,
			'{64'h8000_0000_0000_0000, 1'b0}},
		'{'{REQ_SET,  16'd65535, 17'd1,      10'd0,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_READ, 16'd0,     17'd0,      10'd1023, 64'd0},     1'b1, '{64'd1, 1'b0}},
		'{'{REQ_SET,  16'd65500, 17'd100,    10'd0,    64'd0},     1'b1, '{64'd0, 1'b1}},
		'{'{REQ_SET,  16'd65535, 17'd131071, 10'd0,    64'd0},     1'b1, '{64'd0, 1'b1}},
		'{'{REQ_READ, 16'd0,     17'd0,      10'd1023, 64'd0},     1'b1,
			'{64'h0000_000F_FFFF_FFFF, 1'b0}},
		'{'{REQ_SET,  16'd3,     17'd200,    10'd0,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_READ, 16'd0,     17'd0,      10'd0,    64'd0},     1'b0, '{64'd0, 1'b0}},
		'{'{REQ_OR,   16'd0,     17'd0,      10'd5,    ONES_WORD}, 1'b1, '{ONES_WORD, 1'b0}},
		'{'{REQ_OR,   16'd0,     17'd0,      10'd6,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_OR,   16'd0,     17'd0,      10'd7,    PATTERN},   1'b1, '{PATTERN, 1'b0}},
		'{'{REQ_ZERO, 16'd0,     17'd65,     10'd0,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_READ, 16'd0,     17'd0,      10'd1,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_READ, 16'd0,     17'd0,      10'd3,    64'd0},     1'b0, '{64'd0, 1'b0}},
		'{'{REQ_ZERO, 16'd0,     17'd131071, 10'd0,    64'd0},     1'b1, '{64'd0, 1'b1}},
		'{'{REQ_READ, 16'd0,     17'd0,      10'd7,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_SET,  16'd0,     17'd65536,  10'd0,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_READ, 16'd0,     17'd0,      10'd512,  64'd0},     1'b1, '{ONES_WORD, 1'b0}},
		'{'{REQ_ZERO, 16'd0,     17'd65536,  10'd0,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_SET,  16'd64,    17'd64,     10'd0,    64'd0},     1'b1, '{64'd0, 1'b0}},
		'{'{REQ_READ, 16'd0,     17'd0,      10'd1,    64'd0},     1'b1, '{ONES_WORD, 1'b0}},
		'{'{REQ_READ, 16'd0,     17'd0,      10'd2,    64'd0},     1'b1, '{64'd0, 1'b0}}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        req_type;
	logic [15:0]       start_bit;
	logic [16:0]       bit_count;
	logic [9:0]        word_index;
	logic [63:0]       word_data;
	logic              out_valid;
	logic              out_stall;
	logic [DATA_W-1:0] read_data;
	logic              status;

	logic [WORD_BITS-1:0] mark_mirror [STORE_WORDS];
	bitmap_result_t       owed_results [$];
	int                   items_sent;
	int                   results_seen;
	int                   clipped_seen;
	int                   errors;
	int                   kind_count [4];

	bitmap_range_set_engine u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.start_bit  (start_bit),
		.bit_count  (bit_count),
		.word_index (word_index),
		.word_data  (word_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Applies one request to the mirror of the mark bits and returns the result it owes.
	function automatic bitmap_result_t apply_to_mirror(input bitmap_req_t r);
		bitmap_result_t res;
		int unsigned    first;
		int unsigned    stop;
		int unsigned    nwords;
		int unsigned    lo;
		int unsigned    hi;
		int unsigned    w;
		res   = '0;
		first = 32'(r.start_bit);
		stop  = first + 32'(r.bit_count);
		case (r.kind)
			REQ_SET: begin
				if (r.bit_count != 0) begin
					if (stop > TOTAL_BITS) begin
						stop = TOTAL_BITS;
						res.status = 1'b1;
					end
					if (first < stop) begin
						for (w = first / WORD_BITS; w <= (stop - 1) / WORD_BITS; w++) begin
							lo = (w == first / WORD_BITS) ? first % WORD_BITS : 0;
							hi = (w == (stop - 1) / WORD_BITS) ? (stop - 1) % WORD_BITS
								: WORD_BITS - 1;
							mark_mirror[w] |= (FULL_WORD >> lo) & (FULL_WORD << (WORD_BITS - 1 - hi));
						end
					end
				end
			end
			REQ_ZERO: begin
				// Every word touched by the prefix is cleared, even a partly covered last one.
				nwords = (32'(r.bit_count) + WORD_BITS - 1) / WORD_BITS;
				if (nwords > STORE_WORDS) begin
					nwords = STORE_WORDS;
					res.status = 1'b1;
				end
				for (w = 0; w < nwords; w++)
					mark_mirror[w] = '0;
			end
			default: begin
				if (r.word_index >= STORE_WORDS) begin
					res.status = 1'b1;
				end else begin
					if (r.kind == REQ_OR)
						mark_mirror[r.word_index] |= r.word_data[WORD_BITS-1:0];
					res.read_data = mark_mirror[r.word_index];
				end
			end
		endcase
		return res;
	endfunction

	// Most traffic lands in the low 128 words so reads see earlier sets and merges.
	function automatic bitmap_req_t random_request();
		bitmap_req_t r;
		int          p;
		int          q;
		r.start_bit  = 16'($urandom);
		r.bit_count  = 17'($urandom);
		r.word_index = 10'($urandom);
		r.word_data  = {$urandom, $urandom};
		p = $urandom_range(99);
		q = $urandom_range(99);
		if (p < 40) begin
			r.kind = REQ_SET;
			if (q < 70) begin
				r.start_bit = 16'($urandom_range(0, 8191));
				r.bit_count = 17'($urandom_range(0, 300));
			end else if (q < 85) begin
				r.bit_count = 17'($urandom_range(1, 200));
			end else if (q < 95) begin
				r.start_bit = 16'(65535 - $urandom_range(0, 300));
				r.bit_count = 17'($urandom_range(0, 131071));
			end else if (q < 98) begin
				r.start_bit = 16'($urandom_range(0, 4095));
				r.bit_count = 17'($urandom_range(0, 65536));
			end
		end else if (p < 50) begin
			r.kind = REQ_ZERO;
			if (q < 90)
				r.bit_count = 17'($urandom_range(0, 1200));
		end else begin
			r.kind = (p < 75) ? REQ_OR : REQ_READ;
			if (q < 70)
				r.word_index = 10'($urandom_range(0, 127));
			if (q >= 90)
				r.word_data = 64'd1 << $urandom_range(0, 63);
		end
		return r;
	endfunction

	function automatic int sender_gap();
		int p;
		if ((items_sent >= 100 && items_sent < 200) || (items_sent >= 300 && items_sent < 360))
			return 0;
		p = $urandom_range(99);
		if (p < 60)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Holds the item on the bus until it is taken, then records what it owes.
	task automatic offer_item(input bitmap_req_t r);
		bitmap_result_t owed;
		owed       = apply_to_mirror(r);
		in_valid   <= 1'b1;
		req_type   <= r.kind;
		start_bit  <= r.start_bit;
		bit_count  <= r.bit_count;
		word_index <= r.word_index;
		word_data  <= r.word_data;
		do @(posedge clk); while (in_stall !== 1'b0);
		owed_results.push_back(owed);
		kind_count[r.kind]++;
		items_sent++;
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		bitmap_req_t r;
		in_valid   = 1'b0;
		req_type   = REQ_SET;
		start_bit  = '0;
		bit_count  = '0;
		word_index = '0;
		word_data  = '0;
		arst_n     = 1'b0;
		items_sent   = 0;
		errors       = 0;
		kind_count   = '{default: 0};
		foreach (mark_mirror[w])
			mark_mirror[w] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			r = DIRECTED[i].req;
			offer_item(r);
			// A typed row replaces the predicted value with the one written in the table.
			if (DIRECTED[i].typed) begin
				void'(owed_results.pop_back());
				owed_results.push_back(DIRECTED[i].want);
			end
			idle_sender(sender_gap());
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 450) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (owed_results.size() != 0);
			end
			offer_item(random_request());
			idle_sender(sender_gap());
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (owed_results.size() != 0);
		repeat (40) @(posedge clk);
		$display("Summary: %0d requests (%0d set, %0d zero, %0d or, %0d read), %0d results checked.",
			items_sent, kind_count[REQ_SET], kind_count[REQ_ZERO], kind_count[REQ_OR],
			kind_count[REQ_READ], results_seen);
		$display("Summary: %0d results reported a clipped range; %0d mismatches.",
			clipped_seen, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Random stall runs, one long hold-off to fill the block, and a quiet window.
	initial begin : receiver
		int run_left;
		int hold_left;
		int p;
		bit hold_done;
		bit stall_now;
		run_left  = 0;
		hold_left = 0;
		hold_done = 1'b0;
		stall_now = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && items_sent >= 300) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (items_sent >= 100 && items_sent < 200) begin
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					p = $urandom_range(99);
					if (p < 60) begin
						stall_now = 1'b0;
						run_left  = $urandom_range(1, 20);
					end else if (p < 90) begin
						stall_now = 1'b1;
						run_left  = $urandom_range(1, 4);
					end else begin
						stall_now = 1'b1;
						run_left  = $urandom_range(10, 40);
					end
				end
				run_left--;
				out_stall <= stall_now;
			end
		end
	end

	initial results_seen = 0;
	initial clipped_seen = 0;

	always @(posedge clk) begin : check_results
		bitmap_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (owed_results.size() == 0) begin
				$display("%0t: result with nothing outstanding: read_data %h status %0d",
					$time, read_data, status);
				errors++;
			end else begin
				want = owed_results.pop_front();
				results_seen++;
				if (status === 1'b1)
					clipped_seen++;
				if (read_data !== want.read_data) begin
					$display("%0t: read_data mismatch: expected %h, got %h",
						$time, want.read_data, read_data);
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, got %0d",
						$time, want.status, status);
					errors++;
				end
			end
		end
	end

endmodule

FILE: filelist.f
hw/rtl/brs_pkg.sv
hw/rtl/bitmap_range_set_engine.sv
test/tb_top.sv
